// ----- rtl/csc_pkg.sv -----
// shared types, constants and coefficient tables for the color space converter
package csc_pkg;

  localparam int FRAC_BITS      = 4;
  localparam int COEF_FRAC_BITS = 14;

  localparam int FIELD_W = 14;
  localparam int MODE_W  = 3;
  localparam int X_W     = FIELD_W + 1;          // room for the chroma offset removal
  localparam int COEF_W  = 17;
  localparam int PROD_W  = X_W + COEF_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int Y_W     = ACC_W - COEF_FRAC_BITS;

  localparam int FIELD_MIN = -(2 ** (FIELD_W - 1));
  localparam int FIELD_MAX = (2 ** (FIELD_W - 1)) - 1;
  localparam int OFFSET    = 128 * (2 ** FRAC_BITS);
  localparam int TOP       = 255 * (2 ** FRAC_BITS);
  localparam int HALF      = 2 ** (COEF_FRAC_BITS - 1);

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic [MODE_W-1:0]         mode_t;
  typedef logic signed [X_W-1:0]     x_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [Y_W-1:0]     y_t;
  typedef coef_t [0:8]               coef_set_t;

  localparam mode_t MODE_RGB_YUV   = 3'd0;
  localparam mode_t MODE_YUV_RGB   = 3'd1;
  localparam mode_t MODE_RGB_YIQ   = 3'd2;
  localparam mode_t MODE_YIQ_RGB   = 3'd3;
  localparam mode_t MODE_RGB_YCBCR = 3'd4;
  localparam mode_t MODE_YCBCR_RGB = 3'd5;

  // row-major 3x3 matrix, coefficients with COEF_FRAC_BITS fraction bits
  function automatic coef_set_t coef_set(input mode_t mode);
    coef_set_t c;
    case (mode)
      MODE_RGB_YUV: begin
        c = '{17'sd4899, 17'sd9617, 17'sd1868,
              -17'sd2411, -17'sd4733, 17'sd7143,
              17'sd10076, -17'sd8438, -17'sd1639};
      end
      MODE_YUV_RGB: begin
        c = '{17'sd16384, 17'sd0, 17'sd18675,
              17'sd16384, -17'sd6466, -17'sd9513,
              17'sd16384, 17'sd33294, 17'sd0};
      end
      MODE_RGB_YIQ: begin
        c = '{17'sd4899, 17'sd9617, 17'sd1868,
              17'sd9763, -17'sd4499, -17'sd5264,
              17'sd3465, -17'sd8564, 17'sd5099};
      end
      MODE_YIQ_RGB: begin
        c = '{17'sd16384, 17'sd15663, 17'sd10142,
              17'sd16384, -17'sd4456, -17'sd10600,
              17'sd16384, -17'sd18121, 17'sd27902};
      end
      MODE_RGB_YCBCR: begin
        c = '{17'sd4899, 17'sd9617, 17'sd1868,
              -17'sd2765, -17'sd5427, 17'sd8192,
              17'sd8192, -17'sd6860, -17'sd1332};
      end
      MODE_YCBCR_RGB: begin
        c = '{17'sd16384, 17'sd0, 17'sd22970,
              17'sd16384, -17'sd5638, -17'sd11700,
              17'sd16384, 17'sd29032, 17'sd0};
      end
      default: begin
        // unused codes: identity, the pixel comes out unchanged
        c = '{17'sd16384, 17'sd0, 17'sd0,
              17'sd0, 17'sd16384, 17'sd0,
              17'sd0, 17'sd0, 17'sd16384};
      end
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/color_space_converter_unit.sv -----
// pipelined 3x3 color matrix converter: rgb to/from yuv, yiq and full-range ycbcr
//
// Usage:
//   A pixel request is taken on a rising edge with start high and busy low.
//   busy is only high while rst_n is low; otherwise a pixel can be taken
//   every cycle. Each result appears on out_a/out_b/out_c for one cycle with
//   out_strobe high, after its request has passed the input register, multiply
//   stage, sum and round stage and clamp stage. Throughput is one pixel
//   per clock, set by the nine multipliers with mode-selected coefficients working in
//   parallel. The receiver cannot hold results off, so nothing stalls.
//   The mode register is written over cfg_valid/cfg_ready/cfg_data and is
//   sampled when a pixel enters; each pixel carries its mode down the pipe.
//   Change it only while no pixels are in flight.
//   Reset (synchronous, active low) empties the pipeline and sets mode 0
//   (rgb to yuv). cfg_ready is low during reset.
//   Modes: 0 rgb>yuv, 1 yuv>rgb, 2 rgb>yiq, 3 yiq>rgb, 4 rgb>ycbcr,
//   5 ycbcr>rgb, 6 and 7 pass the pixel through.
module color_space_converter_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  csc_pkg::field_t in_comp_a,
  input  csc_pkg::field_t in_comp_b,
  input  csc_pkg::field_t in_comp_c,
  output logic            out_strobe,
  output csc_pkg::field_t out_a,
  output csc_pkg::field_t out_b,
  output csc_pkg::field_t out_c,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  csc_pkg::mode_t  cfg_data
);
  import csc_pkg::*;

  localparam x_t                OFFSET_X = X_W'(OFFSET);
  localparam logic signed [Y_W:0] OFFSET_Y = (Y_W + 1)'(OFFSET);

  mode_t     mode_r;

  logic      s1_valid_r;
  mode_t     s1_mode_r;
  x_t        s1_x_r [3];

  logic      s2_valid_r;
  mode_t     s2_mode_r;
  prod_t     s2_prod_r [9];

  logic      s3_valid_r;
  mode_t     s3_mode_r;
  y_t        s3_y_r [3];

  logic      out_strobe_r;
  field_t    out_a_r;
  field_t    out_b_r;
  field_t    out_c_r;

  logic      accept;
  logic      in_ycbcr_inv;
  coef_set_t s1_coef;
  acc_t      acc [3];
  y_t        y_nxt [3];
  logic      s3_inv;
  logic      s3_add_off;

  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RGB_YUV;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  // stage 1: register the pixel, remove the chroma offset for ycbcr input
  assign in_ycbcr_inv = (mode_r == MODE_YCBCR_RGB);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r <= mode_r;
      s1_x_r[0] <= X_W'(in_comp_a);
      s1_x_r[1] <= X_W'(in_comp_b) - (in_ycbcr_inv ? OFFSET_X : '0);
      s1_x_r[2] <= X_W'(in_comp_c) - (in_ycbcr_inv ? OFFSET_X : '0);
    end
  end

  // stage 2: nine products
  assign s1_coef = coef_set(s1_mode_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_mode_r <= s1_mode_r;
    for (int k = 0; k < 9; k++) begin
      s2_prod_r[k] <= PROD_W'(s1_x_r[k % 3]) * PROD_W'(s1_coef[k]);
    end
  end

  // stage 3: row sums, round to nearest with ties up, drop coefficient fraction
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = ACC_W'(s2_prod_r[3 * i]) + ACC_W'(s2_prod_r[3 * i + 1])
             + ACC_W'(s2_prod_r[3 * i + 2]) + ACC_W'(HALF);
      y_nxt[i] = acc[i][ACC_W-1:COEF_FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_mode_r <= s2_mode_r;
    for (int i = 0; i < 3; i++) begin
      s3_y_r[i] <= y_nxt[i];
    end
  end

  // stage 4: chroma offset, clamp and saturate
  assign s3_inv     = s3_mode_r inside {MODE_YUV_RGB, MODE_YIQ_RGB, MODE_YCBCR_RGB};
  assign s3_add_off = (s3_mode_r == MODE_RGB_YCBCR);

  function automatic field_t post_proc(input y_t y, input logic inv, input logic add_off);
    logic signed [Y_W:0] v;
    field_t              r;
    v = {y[Y_W-1], y} + (add_off ? OFFSET_Y : '0);
    if (inv) begin
      // back to rgb: clamp to 0..255 and keep the whole part
      if (y < 0) begin
        r = '0;
      end else if (y > TOP) begin
        r = FIELD_W'(TOP);
      end else begin
        r = {y[FIELD_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
      end
    end else if (v < FIELD_MIN) begin
      r = FIELD_W'(FIELD_MIN);
    end else if (v > FIELD_MAX) begin
      r = FIELD_W'(FIELD_MAX);
    end else begin
      r = v[FIELD_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_a_r <= post_proc(s3_y_r[0], s3_inv, 1'b0);
    out_b_r <= post_proc(s3_y_r[1], s3_inv, s3_add_off);
    out_c_r <= post_proc(s3_y_r[2], s3_inv, s3_add_off);
  end

  assign out_strobe = out_strobe_r;
  assign out_a      = out_a_r;
  assign out_b      = out_b_r;
  assign out_c      = out_c_r;

  // every request comes out on out_strobe after passing the pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_strobe)
    else $error("request did not reach the output after four cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 4))
    else $error("result without a matching request");

  // rgb results are whole values in 0..255
  a_rgb_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && s3_inv |=> out_strobe
      && out_a[FRAC_BITS-1:0] == '0 && !out_a[FIELD_W-1] && out_a <= TOP
      && out_b[FRAC_BITS-1:0] == '0 && !out_b[FIELD_W-1] && out_b <= TOP
      && out_c[FRAC_BITS-1:0] == '0 && !out_c[FIELD_W-1] && out_c <= TOP)
    else $error("rgb result not clamped to a whole value");

  // unused mode codes pass the pixel through
  a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    accept && mode_r[2] && mode_r[1] |-> ##4 out_strobe
      && out_a == $past(in_comp_a, 4) && out_b == $past(in_comp_b, 4)
      && out_c == $past(in_comp_c, 4))
    else $error("pass-through mode altered the pixel");

endmodule
